// ===== rtl/sttc_pkg.sv =====
// shadow type tag checker package: operation, status and sequencer state codes
// plus tag constants and default sizes; no dependencies
package sttc_pkg;

   localparam int OP_W         = 3;
   localparam int TAG_W        = 8;
   localparam int LEN_W        = 13;
   localparam int STATUS_W     = 2;
   localparam int ADDR_BITS_DEF = 16;
   localparam int MAX_LEN_DEF   = 4096;

   localparam logic [TAG_W-1:0] ANY_TAG  = 8'hFF;
   localparam logic [TAG_W-1:0] NONE_TAG = 8'h00;

   typedef enum logic [OP_W-1:0] {
      OP_STORE = 3'd0,
      OP_LOAD  = 3'd1,
      OP_INIT  = 3'd2,
      OP_CLEAR = 3'd3,
      OP_COPY  = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK             = 2'd0,
      ST_TYPE_MISMATCH  = 2'd1,
      ST_ALIGN_MISMATCH = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_FILL,
      S_CP_RD,
      S_CP_WR,
      S_LD_RD,
      S_LD_CHK
   } state_type;

endpackage

// ===== rtl/sttc_tag_ram.sv =====
// shadow tag memory: one write port, one read port, registered read data
// depends on sttc_pkg
module sttc_tag_ram #(
   parameter int ADDR_BITS = sttc_pkg::ADDR_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ADDR_BITS-1:0]       wr_addr,
   input  logic [sttc_pkg::TAG_W-1:0] wr_data,
   input  logic [ADDR_BITS-1:0]       rd_addr,
   output logic [sttc_pkg::TAG_W-1:0] rd_data
);
   import sttc_pkg::*;

   localparam longint Depth = longint'(1) << ADDR_BITS;

   logic [TAG_W-1:0] mem_ff [Depth];
   logic [TAG_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/shadow_type_tag_checker.sv =====
// shadow type tag checker top level: sequencer that walks byte ranges of the tag store
// depends on sttc_pkg and sttc_tag_ram
//
//   channel   ports                                   handshake
//   request   req_op req_addr req_src_addr            start, taken when busy is low
//             req_type_code req_length
//   response  rsp_status rsp_found_tag                rsp_valid, one cycle per beat
//
// store, init, clear: one cycle per byte; copy: each byte is read, then written back
// load: each byte is read, then checked; one cycle per byte when the range is retagged
// zero length or undefined op: response in the cycle after the beat is taken
// after reset, busy stays high while the store is zeroed
// the response strobe cannot be held off; each beat gets exactly one response
module shadow_type_tag_checker #(
   parameter int ADDR_BITS = sttc_pkg::ADDR_BITS_DEF,
   parameter int MAX_LEN   = sttc_pkg::MAX_LEN_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [sttc_pkg::OP_W-1:0]     req_op,
   input  logic [ADDR_BITS-1:0]          req_addr,
   input  logic [ADDR_BITS-1:0]          req_src_addr,
   input  logic [sttc_pkg::TAG_W-1:0]    req_type_code,
   input  logic [sttc_pkg::LEN_W-1:0]    req_length,
   output logic                          rsp_valid,
   output logic [sttc_pkg::STATUS_W-1:0] rsp_status,
   output logic [sttc_pkg::TAG_W-1:0]    rsp_found_tag
);
   import sttc_pkg::*;

   localparam int LEN_BITS = $clog2(MAX_LEN + 1);

   state_type            state_ff, state_in;
   logic [ADDR_BITS-1:0] clr_ff, clr_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic [ADDR_BITS-1:0] src_ff, src_in;
   logic [TAG_W-1:0]     code_ff, code_in;
   logic [LEN_BITS-1:0]  len_ff, len_in;
   logic [LEN_BITS-1:0]  idx_ff, idx_in;
   logic [TAG_W-1:0]     first_ff, first_in;
   logic [TAG_W-1:0]     fill_ff, fill_in;
   logic                 any_ff, any_in;
   status_type           status_ff, status_in;
   logic [TAG_W-1:0]     found_ff, found_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [TAG_W-1:0]     rsp_found_ff, rsp_found_in;

   logic                 mem_we;
   logic [ADDR_BITS-1:0] mem_waddr;
   logic [TAG_W-1:0]     mem_wdata;
   logic [ADDR_BITS-1:0] mem_raddr;
   logic [TAG_W-1:0]     mem_rdata;

   logic [ADDR_BITS-1:0] dst_addr;
   logic [ADDR_BITS-1:0] rd_src_addr;
   logic                 last_byte;
   logic [LEN_BITS-1:0]  len_sat;
   logic                 go_on;
   logic                 finish;
   logic [TAG_W-1:0]     expect_tag;

   sttc_tag_ram #(
      .ADDR_BITS(ADDR_BITS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_addr(mem_raddr),
      .rd_data(mem_rdata)
   );

   assign dst_addr    = addr_ff + ADDR_BITS'(idx_ff);
   assign rd_src_addr = src_ff + ADDR_BITS'(idx_ff);
   assign last_byte   = (idx_ff == len_ff - LEN_BITS'(1));
   assign expect_tag  = any_ff ? ANY_TAG : NONE_TAG;
   assign len_sat     = (32'(req_length) > 32'(MAX_LEN)) ? LEN_BITS'(MAX_LEN)
                                                         : LEN_BITS'(req_length);

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      addr_in       = addr_ff;
      src_in        = src_ff;
      code_in       = code_ff;
      len_in        = len_ff;
      idx_in        = idx_ff;
      first_in      = first_ff;
      fill_in       = fill_ff;
      any_in        = any_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      mem_we        = 1'b0;
      mem_waddr     = dst_addr;
      mem_wdata     = fill_ff;
      mem_raddr     = dst_addr;
      go_on         = 1'b0;
      finish        = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = NONE_TAG;
            clr_in    = clr_ff + ADDR_BITS'(1);
            if (&clr_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               addr_in   = req_addr;
               src_in    = req_src_addr;
               code_in   = req_type_code;
               len_in    = len_sat;
               idx_in    = '0;
               any_in    = 1'b0;
               status_in = ST_OK;
               found_in  = NONE_TAG;
               case (op_type'(req_op))
                  OP_STORE: begin
                     first_in = req_type_code;
                     fill_in  = NONE_TAG;
                     state_in = S_FILL;
                  end
                  OP_INIT: begin
                     first_in = ANY_TAG;
                     fill_in  = ANY_TAG;
                     state_in = S_FILL;
                  end
                  OP_CLEAR: begin
                     first_in = NONE_TAG;
                     fill_in  = NONE_TAG;
                     state_in = S_FILL;
                  end
                  OP_COPY: begin
                     state_in = S_CP_RD;
                  end
                  OP_LOAD: begin
                     state_in = S_LD_RD;
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
               if (len_sat == '0) begin
                  finish = 1'b1;
               end
               if (finish) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_FILL: begin
            mem_we    = 1'b1;
            mem_wdata = (idx_ff == '0) ? first_ff : fill_ff;
            if (last_byte) begin
               finish   = 1'b1;
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + LEN_BITS'(1);
            end
         end
         S_CP_RD: begin
            mem_raddr = rd_src_addr;
            state_in  = S_CP_WR;
         end
         S_CP_WR: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata;
            if (last_byte) begin
               finish   = 1'b1;
               state_in = S_IDLE;
            end else begin
               idx_in   = idx_ff + LEN_BITS'(1);
               state_in = S_CP_RD;
            end
         end
         S_LD_RD: begin
            state_in = S_LD_CHK;
         end
         S_LD_CHK: begin
            if (idx_ff == '0) begin
               if (mem_rdata == code_ff) begin
                  any_in = 1'b0;
                  go_on  = 1'b1;
               end else if (mem_rdata == ANY_TAG) begin
                  any_in = 1'b1;
                  go_on  = 1'b1;
               end else begin
                  status_in = ST_TYPE_MISMATCH;
                  found_in  = mem_rdata;
               end
            end else if (mem_rdata != expect_tag) begin
               status_in = ST_ALIGN_MISMATCH;
               found_in  = mem_rdata;
            end else begin
               go_on = 1'b1;
            end
            if (go_on && !last_byte) begin
               idx_in   = idx_ff + LEN_BITS'(1);
               state_in = S_LD_RD;
            end else if (any_in) begin
               // retag the range as a store of the expected type
               first_in = code_ff;
               fill_in  = NONE_TAG;
               idx_in   = '0;
               state_in = S_FILL;
            end else begin
               finish   = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (finish) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_in;
         rsp_found_in  = found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      src_ff        <= src_in;
      code_ff       <= code_in;
      len_ff        <= len_in;
      idx_ff        <= idx_in;
      first_ff      <= first_in;
      fill_ff       <= fill_in;
      any_ff        <= any_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_found_tag = rsp_found_ff;

endmodule

// ===== rtl/sttc_checker.sv =====
// port level checks for the shadow type tag checker, bound to the top level
// depends on sttc_pkg and shadow_type_tag_checker
module sttc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic [sttc_pkg::STATUS_W-1:0] rsp_status,
   input logic [sttc_pkg::TAG_W-1:0]    rsp_found_tag
);
   import sttc_pkg::*;

   // store is zeroed after reset before any beat is taken
   a_reset_busy: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low right after reset");

   // a response only follows a taken beat or ongoing work
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy || start))
      else $error("response without a request");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_TYPE_MISMATCH ||
                     rsp_status == ST_ALIGN_MISMATCH))
      else $error("undefined status code");

   a_ok_no_tag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_OK) |-> (rsp_found_tag == NONE_TAG))
      else $error("found tag set on ok response");

endmodule

bind shadow_type_tag_checker sttc_checker u_sttc_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_status   (rsp_status),
   .rsp_found_tag(rsp_found_tag)
);

// ===== verif/tb_shadow_type_tag_checker.sv =====
// testbench for shadow_type_tag_checker: a clocked driver feeds request beats from a queue,
// an in-bench tag store mirror predicts each response and a clocked monitor checks it
// depends on sttc_pkg and the rtl of shadow_type_tag_checker
`timescale 1ns / 1ps

module tb_shadow_type_tag_checker;
   import sttc_pkg::*;

   localparam int AW             = ADDR_BITS_DEF;
   localparam int STORE_DEPTH    = 1 << AW;
   localparam int RANDOM_TARGET  = 650;
   localparam int IDLE_PERCENT   = 12;
   localparam int WATCHDOG_LIMIT = 3 * STORE_DEPTH;
   localparam int DRAIN_CYCLES   = 16;
   localparam int OP_LAST        = OP_COPY;
   localparam int OP_MAX         = (1 << OP_W) - 1;
   localparam int LEN_MAX        = (1 << LEN_W) - 1;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [AW-1:0]    addr;
      logic [AW-1:0]    src_addr;
      logic [TAG_W-1:0] type_code;
      logic [LEN_W-1:0] length;
   } tag_request_type;

   typedef struct packed {
      status_type       status;
      logic [TAG_W-1:0] found_tag;
   } tag_verdict_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [OP_W-1:0]     req_op = '0;
   logic [AW-1:0]       req_addr = '0;
   logic [AW-1:0]       req_src_addr = '0;
   logic [TAG_W-1:0]    req_type_code = '0;
   logic [LEN_W-1:0]    req_length = '0;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [TAG_W-1:0]    rsp_found_tag;

   bit [TAG_W-1:0]  tag_mirror [STORE_DEPTH];
   tag_request_type request_queue [$];
   tag_verdict_type verdict_queue [$];
   tag_verdict_type next_verdict;
   tag_verdict_type seen_verdict;
   int             accepted_count = 0;
   int             error_count = 0;
   int             stall_cycles = 0;
   logic           offering;
   logic           hold_off;

   shadow_type_tag_checker dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_op        (req_op),
      .req_addr      (req_addr),
      .req_src_addr  (req_src_addr),
      .req_type_code (req_type_code),
      .req_length    (req_length),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_found_tag (rsp_found_tag)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // mirror of the tag store: applies one beat and returns the expected response
   task automatic apply_tag_request(input tag_request_type rq, output tag_verdict_type vd);
      int             n;
      logic [AW-1:0]  a;
      logic [TAG_W-1:0] first;
      logic [TAG_W-1:0] b;
      n = (rq.length > MAX_LEN_DEF) ? MAX_LEN_DEF : int'(rq.length);
      vd.status = ST_OK;
      vd.found_tag = NONE_TAG;
      case (rq.op)
         OP_STORE: begin
            for (int i = 0; i < n; i++) begin
               a = rq.addr + AW'(i);
               tag_mirror[a] = (i == 0) ? rq.type_code : NONE_TAG;
            end
         end
         OP_LOAD: begin
            if (n != 0) begin
               first = tag_mirror[rq.addr];
               if (first == rq.type_code || first == ANY_TAG) begin
                  for (int i = 1; i < n; i++) begin
                     a = rq.addr + AW'(i);
                     b = tag_mirror[a];
                     if (vd.status == ST_OK &&
                         b != ((first == rq.type_code) ? NONE_TAG : ANY_TAG)) begin
                        vd.status = ST_ALIGN_MISMATCH;
                        vd.found_tag = b;
                     end
                  end
                  if (first != rq.type_code) begin
                     for (int i = 0; i < n; i++) begin
                        a = rq.addr + AW'(i);
                        tag_mirror[a] = (i == 0) ? rq.type_code : NONE_TAG;
                     end
                  end
               end else begin
                  vd.status = ST_TYPE_MISMATCH;
                  vd.found_tag = first;
               end
            end
         end
         OP_INIT, OP_CLEAR: begin
            for (int i = 0; i < n; i++) begin
               a = rq.addr + AW'(i);
               tag_mirror[a] = (rq.op == OP_INIT) ? ANY_TAG : NONE_TAG;
            end
         end
         OP_COPY: begin
            for (int i = 0; i < n; i++) begin
               a = rq.addr + AW'(i);
               tag_mirror[a] = tag_mirror[AW'(rq.src_addr + AW'(i))];
            end
         end
         default: begin
         end
      endcase
   endtask

   task automatic add_request(input logic [OP_W-1:0] op, input logic [AW-1:0] a,
                              input logic [AW-1:0] s, input logic [TAG_W-1:0] c,
                              input int n);
      tag_request_type rq;
      rq.op = op;
      rq.addr = a;
      rq.src_addr = s;
      rq.type_code = c;
      rq.length = LEN_W'(n);
      request_queue.push_back(rq);
   endtask

   task automatic build_random_part();
      int               kind;
      int               n;
      logic [AW-1:0]    base;
      logic [AW-1:0]    other;
      logic [TAG_W-1:0] code;
      while (request_queue.size() < RANDOM_TARGET) begin
         kind = $urandom_range(0, 9);
         base = ($urandom_range(0, 3) == 0) ? AW'($urandom) : AW'($urandom_range(0, 31) * 8);
         other = ($urandom_range(0, 3) == 0) ? AW'($urandom) : AW'($urandom_range(0, 31) * 8);
         n = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 12);
         if ($urandom_range(0, 39) == 0)
            n = $urandom_range(13, LEN_MAX);
         code = ($urandom_range(0, 15) == 0) ? TAG_W'($urandom) : TAG_W'($urandom_range(1, 254));
         case (kind)
            0, 1: begin
               add_request(OP_STORE, base, AW'($urandom), code, n);
               add_request(OP_LOAD, base, AW'($urandom),
                           ($urandom_range(0, 3) == 0) ? TAG_W'($urandom) : code,
                           ($urandom_range(0, 1) == 0) ? n : $urandom_range(1, 16));
            end
            2: begin
               add_request(OP_STORE, base, AW'($urandom), code, n);
               add_request(OP_LOAD, base + AW'($urandom_range(0, 3)), AW'($urandom), code, n);
            end
            3, 4: begin
               add_request(OP_INIT, base, AW'($urandom), code, n);
               add_request(OP_LOAD, base + AW'($urandom_range(0, 1)), AW'($urandom), code,
                           ($urandom_range(0, 1) == 0) ? n : $urandom_range(1, 16));
               add_request(OP_LOAD, base, AW'($urandom), code, n);
            end
            5: begin
               add_request(OP_STORE, other, AW'($urandom), code, n);
               add_request(OP_COPY, base, other, TAG_W'($urandom), n);
               add_request(OP_LOAD, base, AW'($urandom), code, n);
            end
            6: begin
               add_request(OP_CLEAR, base, AW'($urandom), code, n);
               add_request(OP_LOAD, base, AW'($urandom),
                           ($urandom_range(0, 1) == 0) ? NONE_TAG : code, n);
            end
            7: begin
               add_request(OP_W'($urandom_range(0, OP_MAX)), AW'($urandom), AW'($urandom),
                           TAG_W'($urandom), $urandom_range(0, 20));
            end
            8: begin
               add_request(OP_LOAD, base, AW'($urandom), code, n);
            end
            default: begin
               add_request(OP_W'(OP_LAST + $urandom_range(1, OP_MAX - OP_LAST)), AW'($urandom),
                           AW'($urandom), TAG_W'($urandom), $urandom_range(0, LEN_MAX));
            end
         endcase
      end
   endtask

   initial begin
      // typed store, exact load, wrong type, trailing tag in range
      add_request(OP_STORE, 16'h0000, 16'h0000, 8'h5A, 4);
      add_request(OP_LOAD, 16'h0000, 16'hFFFF, 8'h5A, 4);
      add_request(OP_LOAD, 16'h0000, 16'h0000, 8'h11, 1);
      add_request(OP_STORE, 16'h0004, 16'h0000, 8'h33, 2);
      add_request(OP_LOAD, 16'h0000, 16'h0000, 8'h5A, 8);
      // any-type range: retag on load, then a stray tag inside it
      add_request(OP_INIT, 16'h0100, 16'h0000, 8'h00, 8);
      add_request(OP_LOAD, 16'h0100, 16'h0000, 8'h22, 8);
      add_request(OP_LOAD, 16'h0100, 16'h0000, 8'h22, 8);
      add_request(OP_INIT, 16'h0200, 16'h0000, 8'h00, 4);
      add_request(OP_STORE, 16'h0203, 16'h0000, 8'h44, 1);
      add_request(OP_LOAD, 16'h0200, 16'h0000, 8'h07, 4);
      add_request(OP_CLEAR, 16'h0100, 16'h0000, 8'hFF, 8);
      add_request(OP_LOAD, 16'h0100, 16'h0000, 8'h00, 8);
      add_request(OP_LOAD, 16'h0100, 16'h0000, 8'h05, 8);
      // wrap past the top of the store
      add_request(OP_INIT, 16'hFFFC, 16'h0000, 8'h00, 8);
      add_request(OP_LOAD, 16'hFFFE, 16'h0000, 8'hFE, 4);
      // overlapping copy smears the first tag forward
      add_request(OP_STORE, 16'h0300, 16'h0000, 8'h77, 1);
      add_request(OP_COPY, 16'h0301, 16'h0300, 8'h00, 4);
      add_request(OP_LOAD, 16'h0304, 16'h0000, 8'h77, 1);
      // zero length, oversize length, reserved tag code
      add_request(OP_STORE, 16'h0400, 16'h0000, 8'h12, 0);
      add_request(OP_LOAD, 16'h0000, 16'h0000, 8'h99, 0);
      add_request(OP_INIT, 16'hF800, 16'hFFFF, 8'hFF, LEN_MAX);
      add_request(OP_LOAD, 16'hF800, 16'h0000, 8'hFF, MAX_LEN_DEF);
      add_request(OP_COPY, 16'h8000, 16'hF800, 8'h00, MAX_LEN_DEF);
      for (int k = OP_LAST + 1; k <= OP_MAX; k++)
         add_request(OP_W'(k), 16'hFFFF, 16'hFFFF, 8'hFF, LEN_MAX);
      build_random_part();

      do @(negedge clock);
      while (request_queue.size() != 0 || verdict_queue.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         offering = start;
         if (start && !busy) begin
            apply_tag_request(request_queue[0], next_verdict);
            verdict_queue.push_back(next_verdict);
            request_queue.delete(0);
            accepted_count++;
            offering = 1'b0;
         end
         if (!offering) begin
            hold_off = !(accepted_count >= 250 && accepted_count < 400) &&
                       ($urandom_range(0, 99) < IDLE_PERCENT);
            if (request_queue.size() != 0 && !hold_off) begin
               start <= 1'b1;
               req_op <= request_queue[0].op;
               req_addr <= request_queue[0].addr;
               req_src_addr <= request_queue[0].src_addr;
               req_type_code <= request_queue[0].type_code;
               req_length <= request_queue[0].length;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (verdict_queue.size() == 0) begin
            $error("response beat with no request outstanding: status %0d found_tag %0h",
                   rsp_status, rsp_found_tag);
            error_count++;
         end else begin
            seen_verdict = verdict_queue.pop_front();
            if (rsp_status !== seen_verdict.status) begin
               $error("rsp_status expected %0d actual %0d", seen_verdict.status, rsp_status);
               error_count++;
            end
            if (rsp_found_tag !== seen_verdict.found_tag) begin
               $error("rsp_found_tag expected %0h actual %0h", seen_verdict.found_tag,
                      rsp_found_tag);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((start && !busy && !reset) || (rsp_valid && !reset)) begin
         stall_cycles <= 0;
      end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule
